FILE: rtl/rgb_median_filter_3x3_unit_defines.svh
// assertion macros for the rgb median filter
`ifndef RGB_MEDIAN_FILTER_3X3_UNIT_DEFINES_SVH
`define RGB_MEDIAN_FILTER_3X3_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RMF_ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define RMF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: rtl/rmf_pkg.sv
// shared widths, register indexes and the median network for the rgb median filter
`default_nettype none

package rmf_pkg;

    localparam int unsigned PIXEL_W     = 24;
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned OUT_PIXEL_W = 32;
    localparam int unsigned OUT_COL_W   = 11;
    localparam int unsigned OUT_ROW_W   = 12;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam int unsigned WIDTH_REG_W  = 12;
    localparam int unsigned HEIGHT_REG_W = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam int unsigned             SIZE_MIN     = 3;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    localparam int unsigned WIN_TAPS  = 9;
    localparam int unsigned MED_STEPS = 19;

    typedef logic [3:0]                       tap_idx_t;
    typedef logic [WIN_TAPS-1:0][CHAN_W-1:0]  chan_taps_t;
    typedef logic [WIN_TAPS-1:0][PIXEL_W-1:0] pixel_taps_t;

    // compare-exchange pairs of the nine-input median network, lower tap takes the minimum
    localparam tap_idx_t MED_LO [MED_STEPS] =
        '{4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
          4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4};
    localparam tap_idx_t MED_HI [MED_STEPS] =
        '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
          4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2};

    // fixed network, logic depth of nine comparators; median lands on tap 4
    function automatic logic [CHAN_W-1:0] median9(input chan_taps_t taps);
        chan_taps_t        p;
        logic [CHAN_W-1:0] t;
        p = taps;
        for (int k = 0; k < MED_STEPS; k++)
        begin
            if (p[MED_LO[k]] > p[MED_HI[k]])
            begin
                t              = p[MED_LO[k]];
                p[MED_LO[k]]   = p[MED_HI[k]];
                p[MED_HI[k]]   = t;
            end
        end
        return p[4];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rmf_stream_if.sv
// valid/ready stream interfaces for source pixels and filtered results
`default_nettype none

interface rmf_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [rmf_pkg::PIXEL_W-1:0] pixel_rgb;

    modport source (output valid, output pixel_rgb, input ready);
    modport sink   (input valid, input pixel_rgb, output ready);
endinterface

interface rmf_result_if;
    logic                            valid;
    logic                            ready;
    logic [rmf_pkg::OUT_PIXEL_W-1:0] out_pixel;
    logic [rmf_pkg::OUT_COL_W-1:0]   out_column;
    logic [rmf_pkg::OUT_ROW_W-1:0]   out_row;
    logic                            frame_end;

    modport source (output valid, output out_pixel, output out_column, output out_row,
                    output frame_end, input ready);
    modport sink   (input valid, input out_pixel, input out_column, input out_row,
                    input frame_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/rgb_median_filter_3x3_unit.sv
// top level of the streaming 3x3 rgb median filter
`default_nettype none

`include "rgb_median_filter_3x3_unit_defines.svh"

// Streaming 3x3 median filter for 24-bit RGB pixels delivered in raster order.
// One pixel beat is taken every clock while the result side keeps up. The pixel
// beat that completes a window is held in stage one, where its line memory read
// lands, and the median network then feeds the output register, from which its
// result beat leaves. Each channel's median is taken separately over the nine window
// pixels and sent as alpha 0xFF followed by red, green and blue medians, with
// the column and row of the window centre. Pixels on the frame border are never
// centres, so no result beat is centred on them; frame_end marks the last interior
// pixel. The two previous lines sit in a single line memory of MAX_LINE_WIDTH
// entries, read once and written once per pixel; it needs no clearing pass
// after reset, since entries that were never written only feed border windows.
// Writing image_width or image_height restarts the frame at column 0, row 0.
// Out-of-range sizes are saturated to [3, WIDTH_CAP] and [3, HEIGHT_CAP].
// Configuration must only be written while no pixel is still in flight.
module rgb_median_filter_3x3_unit #(
    parameter int unsigned MAX_LINE_WIDTH = 2048,
    parameter int unsigned MAX_LINES      = 4096
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    rmf_pixel_if.sink                             pixel_in,
    rmf_result_if.source                          result_out,
    input  wire logic                             cfg_we,
    input  wire logic [rmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rmf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // column counter indexes the line memory directly
    localparam int unsigned COL_W = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int unsigned ROW_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    // largest size the parameters and the register fields allow
    localparam int unsigned WIDTH_CAP  = (MAX_LINE_WIDTH < 4095) ? MAX_LINE_WIDTH : 4095;
    localparam int unsigned HEIGHT_CAP = (MAX_LINES < 8191) ? MAX_LINES : 8191;

    localparam int unsigned LINE_W = 2 * rmf_pkg::PIXEL_W;
    localparam int unsigned PW     = rmf_pkg::PIXEL_W;

    // configuration
    logic [rmf_pkg::WIDTH_REG_W-1:0]  image_width_reg;
    logic [rmf_pkg::HEIGHT_REG_W-1:0] image_height_reg;
    logic [rmf_pkg::WIDTH_REG_W-1:0]  width_sat;
    logic [rmf_pkg::HEIGHT_REG_W-1:0] height_sat;

    // position of the next pixel beat
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             col_wrap;
    logic             row_wrap;

    // line memory: upper half two lines back, lower half one line back
    logic [LINE_W-1:0] line_mem [MAX_LINE_WIDTH];
    logic [LINE_W-1:0] line_rd_reg;

    // stage one: accepted pixel waiting for its line memory data
    logic          s1_valid_reg;
    logic [PW-1:0] s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic          s1_emit_reg;
    logic          s1_last_reg;

    // two previous columns of the window, each top, middle, bottom
    logic [PW-1:0] win0_top_reg, win0_mid_reg, win0_bot_reg;
    logic [PW-1:0] win1_top_reg, win1_mid_reg, win1_bot_reg;

    // result register
    logic                            res_valid_reg;
    logic [rmf_pkg::OUT_PIXEL_W-1:0] res_pixel_reg;
    logic [rmf_pkg::OUT_COL_W-1:0]   res_col_reg;
    logic [rmf_pkg::OUT_ROW_W-1:0]   res_row_reg;
    logic                            res_last_reg;

    logic in_fire;
    logic s1_adv;

    rmf_pkg::pixel_taps_t taps;
    rmf_pkg::chan_taps_t  red_taps, green_taps, blue_taps;
    logic [rmf_pkg::CHAN_W-1:0] red_med, green_med, blue_med;
    logic [rmf_pkg::OUT_PIXEL_W-1:0] pixel_next;

    // ---------------------------------------------------------------
    // handshake: stage one moves on when the result register is free,
    // a pixel beat enters whenever stage one is empty or moving on
    // ---------------------------------------------------------------
    assign s1_adv         = s1_valid_reg && (!res_valid_reg || result_out.ready);
    assign pixel_in.ready = !s1_valid_reg || s1_adv;
    assign in_fire        = pixel_in.valid && pixel_in.ready;

    // ---------------------------------------------------------------
    // register saturation on write
    // ---------------------------------------------------------------
    always_comb
    begin
        if (32'(cfg_data[rmf_pkg::WIDTH_REG_W-1:0]) < rmf_pkg::SIZE_MIN)
            width_sat = rmf_pkg::WIDTH_REG_W'(rmf_pkg::SIZE_MIN);
        else if (32'(cfg_data[rmf_pkg::WIDTH_REG_W-1:0]) > WIDTH_CAP)
            width_sat = rmf_pkg::WIDTH_REG_W'(WIDTH_CAP);
        else
            width_sat = cfg_data[rmf_pkg::WIDTH_REG_W-1:0];

        if (32'(cfg_data[rmf_pkg::HEIGHT_REG_W-1:0]) < rmf_pkg::SIZE_MIN)
            height_sat = rmf_pkg::HEIGHT_REG_W'(rmf_pkg::SIZE_MIN);
        else if (32'(cfg_data[rmf_pkg::HEIGHT_REG_W-1:0]) > HEIGHT_CAP)
            height_sat = rmf_pkg::HEIGHT_REG_W'(HEIGHT_CAP);
        else
            height_sat = cfg_data[rmf_pkg::HEIGHT_REG_W-1:0];
    end

    // end of line and end of frame for the pixel now at the input
    assign col_wrap = (32'(col_reg) + 32'd1) == 32'(image_width_reg);
    assign row_wrap = (32'(row_reg) + 32'd1) == 32'(image_height_reg);

    // ---------------------------------------------------------------
    // window taps and the three channel medians
    // ---------------------------------------------------------------
    always_comb
    begin
        taps[0] = win0_top_reg;
        taps[1] = win1_top_reg;
        taps[2] = line_rd_reg[LINE_W-1:PW];
        taps[3] = win0_mid_reg;
        taps[4] = win1_mid_reg;
        taps[5] = line_rd_reg[PW-1:0];
        taps[6] = win0_bot_reg;
        taps[7] = win1_bot_reg;
        taps[8] = s1_pix_reg;
        for (int k = 0; k < rmf_pkg::WIN_TAPS; k++)
        begin
            red_taps[k]   = taps[k][23:16];
            green_taps[k] = taps[k][15:8];
            blue_taps[k]  = taps[k][7:0];
        end
    end

    assign red_med    = rmf_pkg::median9(red_taps);
    assign green_med  = rmf_pkg::median9(green_taps);
    assign blue_med   = rmf_pkg::median9(blue_taps);
    assign pixel_next = {rmf_pkg::ALPHA_OPAQUE, red_med, green_med, blue_med};

    // ---------------------------------------------------------------
    // control and result registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= rmf_pkg::WIDTH_RESET;
            image_height_reg <= rmf_pkg::HEIGHT_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            // a register write restarts the frame
            if (cfg_we && (cfg_index == rmf_pkg::REG_IMAGE_WIDTH ||
                           cfg_index == rmf_pkg::REG_IMAGE_HEIGHT))
            begin
                if (cfg_index == rmf_pkg::REG_IMAGE_WIDTH)
                    image_width_reg <= width_sat;
                else
                    image_height_reg <= height_sat;
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (in_fire)
            begin
                if (col_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_wrap ? '0 : ROW_W'(32'(row_reg) + 32'd1);
                end
                else
                begin
                    col_reg <= COL_W'(32'(col_reg) + 32'd1);
                end
            end

            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv && s1_emit_reg)
                res_valid_reg <= 1'b1;
            else if (result_out.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg  <= pixel_in.pixel_rgb;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_emit_reg <= (32'(col_reg) >= 32'd2) && (32'(row_reg) >= 32'd2);
            s1_last_reg <= col_wrap && row_wrap;
        end

        if (s1_adv)
        begin
            // window shifts by one column
            win0_top_reg <= win1_top_reg;
            win0_mid_reg <= win1_mid_reg;
            win0_bot_reg <= win1_bot_reg;
            win1_top_reg <= line_rd_reg[LINE_W-1:PW];
            win1_mid_reg <= line_rd_reg[PW-1:0];
            win1_bot_reg <= s1_pix_reg;
        end

        if (s1_adv && s1_emit_reg)
        begin
            res_pixel_reg <= pixel_next;
            res_col_reg   <= rmf_pkg::OUT_COL_W'(32'(s1_col_reg) - 32'd1);
            res_row_reg   <= rmf_pkg::OUT_ROW_W'(32'(s1_row_reg) - 32'd1);
            res_last_reg  <= s1_last_reg;
        end
    end

    // ---------------------------------------------------------------
    // line memory: read on the input beat, write as the pixel leaves
    // stage one; consecutive pixels never share a column
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            line_mem[s1_col_reg] <= {line_rd_reg[PW-1:0], s1_pix_reg};
        if (in_fire)
            line_rd_reg <= line_mem[col_reg];
    end

    assign result_out.valid      = res_valid_reg;
    assign result_out.out_pixel  = res_pixel_reg;
    assign result_out.out_column = res_col_reg;
    assign result_out.out_row    = res_row_reg;
    assign result_out.frame_end  = res_last_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `RMF_ASSERT_IMPLIES(a_col_in_line, clk, rst_n, 1'b1,
        32'(col_reg) < 32'(image_width_reg), "column counter beyond line width")
    `RMF_ASSERT_IMPLIES(a_no_mem_collision, clk, rst_n, in_fire && s1_adv,
        col_reg != s1_col_reg, "line memory read and write hit the same column")
    `RMF_ASSERT_IMPLIES(a_centre_interior, clk, rst_n, result_out.valid,
        result_out.out_column != '0 &&
        (32'(result_out.out_column) + 32'd1) < 32'(image_width_reg),
        "result centre column on the border")
    `RMF_ASSERT_IMPLIES(a_frame_end_row, clk, rst_n,
        result_out.valid && result_out.frame_end,
        (32'(result_out.out_row) + 32'd2) == 32'(image_height_reg),
        "frame end flagged away from the last interior row")

endmodule

`default_nettype wire

FILE: sim/rgb_median_filter_3x3_unit_test.sv
// self-checking testbench for the rgb median filter: directed table, then random frames
`timescale 1ns / 1ps

module rgb_median_filter_3x3_unit_test;

    // block sizes, kept equal to the defaults of the top level
    localparam int unsigned MAX_W = 2048;
    localparam int unsigned MAX_H = 4096;

    // quiet cycles before a register write, covers the pipeline with margin
    localparam int unsigned SETTLE_CYCLES = 8;
    // receiver hold-off long enough to fill the pipeline and stall the pixel side
    localparam int unsigned LONG_HOLD     = 300;
    // watchdog: cycles without any beat or write before the run is abandoned
    localparam int unsigned IDLE_LIMIT    = 4000;
    // pixel beats of the random small-frame phases
    localparam int unsigned RANDOM_ITEMS  = 600;
    // power-on sizes: two full lines plus the first few pixels of row two
    localparam int unsigned RESET_PIXELS  = 2 * int'(rmf_pkg::WIDTH_RESET) + 6;
    // cap on printed mismatch lines
    localparam int unsigned REPORT_LIMIT  = 100;

    typedef enum {ROW_WRITE, ROW_PIXEL} row_kind_t;
    typedef enum {CONTENT_UNIFORM, CONTENT_LEVELS, CONTENT_EXTREMES} content_kind_t;

    // one filtered result beat as it should leave the block
    typedef struct packed {
        logic [rmf_pkg::OUT_PIXEL_W-1:0] pixel;
        logic [rmf_pkg::OUT_COL_W-1:0]   column;
        logic [rmf_pkg::OUT_ROW_W-1:0]   row;
        logic                            frame_end;
    } filtered_t;

    // one row of the directed table: a register write or a pixel beat
    typedef struct {
        row_kind_t                       kind;
        logic [rmf_pkg::CFG_INDEX_W-1:0] index;
        logic [rmf_pkg::CFG_DATA_W-1:0]  data;
        logic [rmf_pkg::PIXEL_W-1:0]     rgb;
        bit                              typed;
        filtered_t                       result;
    } stim_row_t;

    typedef logic [rmf_pkg::PIXEL_W-1:0] window_t [9];

    localparam filtered_t NO_RESULT = '0;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                            cfg_we;
    logic [rmf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rmf_pkg::CFG_DATA_W-1:0]  cfg_data;

    rmf_pixel_if  pix_bus ();
    rmf_result_if res_bus ();

    // predictor state: own copy of the line memories, window, counters and sizes
    logic [rmf_pkg::PIXEL_W-1:0] older_line [MAX_W];
    logic [rmf_pkg::PIXEL_W-1:0] newer_line [MAX_W];
    logic [rmf_pkg::PIXEL_W-1:0] win_cols [2][3];
    int unsigned                 col_pos;
    int unsigned                 row_pos;
    int unsigned                 img_width;
    int unsigned                 img_height;

    // filtered beats predicted but not yet seen, oldest first
    filtered_t filtered_pending [$];
    filtered_t oldest_expected;

    stim_row_t directed_rows [33];

    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_cycles  = 0;

    // idling controls shared between the stimulus and the receiver
    bit          steady_src    = 1'b0;
    bit          steady_sink   = 1'b0;
    int unsigned hold_requests = 0;
    int unsigned holds_taken   = 0;

    rgb_median_filter_3x3_unit #(
        .MAX_LINE_WIDTH(MAX_W),
        .MAX_LINES     (MAX_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pix_bus),
        .result_out(res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    // median of one channel over the nine window pixels, by insertion sort
    function automatic logic [rmf_pkg::CHAN_W-1:0] chan_median(input window_t taps,
                                                               input int unsigned shift);
        logic [rmf_pkg::CHAN_W-1:0] v [9];
        logic [rmf_pkg::CHAN_W-1:0] t;
        int                         j;
        for (int i = 0; i < 9; i++)
            v[i] = taps[i][shift +: rmf_pkg::CHAN_W];
        for (int i = 1; i < 9; i++)
        begin
            t = v[i];
            j = i - 1;
            while (j >= 0 && v[j] > t)
            begin
                v[j + 1] = v[j];
                j--;
            end
            v[j + 1] = t;
        end
        return v[4];
    endfunction

    function automatic int unsigned size_clamp(input int unsigned v, input int unsigned hi);
        if (v < rmf_pkg::SIZE_MIN)
            return rmf_pkg::SIZE_MIN;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // advance the predictor by one accepted pixel; queue the filtered beat it causes
    task automatic median_step(input logic [rmf_pkg::PIXEL_W-1:0] rgb, output bit produced);
        int unsigned                 c;
        int unsigned                 r;
        logic [rmf_pkg::PIXEL_W-1:0] top;
        logic [rmf_pkg::PIXEL_W-1:0] mid;
        window_t                     taps;
        filtered_t                   item;
        c = col_pos;
        r = row_pos;
        if (c >= img_width)
            c = 0;
        if (r >= img_height)
            r = 0;
        top = older_line[c];
        mid = newer_line[c];
        // only windows wholly inside the frame give a beat, centred one back
        produced = (c >= 2) && (r >= 2);
        if (produced)
        begin
            taps = '{win_cols[0][0], win_cols[1][0], top,
                     win_cols[0][1], win_cols[1][1], mid,
                     win_cols[0][2], win_cols[1][2], rgb};
            item.pixel     = {rmf_pkg::ALPHA_OPAQUE, chan_median(taps, 16),
                              chan_median(taps, 8), chan_median(taps, 0)};
            item.column    = rmf_pkg::OUT_COL_W'(c - 1);
            item.row       = rmf_pkg::OUT_ROW_W'(r - 1);
            item.frame_end = (c == img_width - 1) && (r == img_height - 1);
            filtered_pending.push_back(item);
        end
        win_cols[0] = win_cols[1];
        win_cols[1] = '{top, mid, rgb};
        older_line[c] = mid;
        newer_line[c] = rgb;
        c++;
        if (c >= img_width)
        begin
            c = 0;
            r++;
            if (r >= img_height)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    // mostly back-to-back, sometimes a few cycles, rarely a long gap
    function automatic int unsigned gap_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [rmf_pkg::PIXEL_W-1:0] random_rgb(input content_kind_t kind);
        logic [rmf_pkg::PIXEL_W-1:0] v;
        v = rmf_pkg::PIXEL_W'($urandom);
        case (kind)
            // few levels per channel, so the median sees many ties
            CONTENT_LEVELS:
                for (int k = 0; k < 3; k++)
                    v[k * rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W] =
                        rmf_pkg::CHAN_W'($urandom_range(0, 3) * 85);
            // each channel fully dark or fully lit
            CONTENT_EXTREMES:
                for (int k = 0; k < 3; k++)
                    v[k * rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W] =
                        {rmf_pkg::CHAN_W{v[k * rmf_pkg::CHAN_W]}};
            default:
                ;
        endcase
        return v;
    endfunction

    function automatic stim_row_t write_row(input logic [rmf_pkg::CFG_INDEX_W-1:0] index,
                                            input logic [rmf_pkg::CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '{ROW_WRITE, index, data, rmf_pkg::PIXEL_W'(0), 1'b0, NO_RESULT};
        return row;
    endfunction

    function automatic stim_row_t pix_row(input logic [rmf_pkg::PIXEL_W-1:0] rgb);
        stim_row_t row;
        row = '{ROW_PIXEL, rmf_pkg::REG_IMAGE_WIDTH, rmf_pkg::CFG_DATA_W'(0), rgb, 1'b0,
                NO_RESULT};
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [rmf_pkg::PIXEL_W-1:0] rgb,
                                            input filtered_t result);
        stim_row_t row;
        row = '{ROW_PIXEL, rmf_pkg::REG_IMAGE_WIDTH, rmf_pkg::CFG_DATA_W'(0), rgb, 1'b1,
                result};
        return row;
    endfunction

    // offer a pixel beat, after a random gap unless steady_src; predict once taken
    task automatic push_pixel(input logic [rmf_pkg::PIXEL_W-1:0] rgb, output bit produced);
        int unsigned gap;
        gap = steady_src ? 0 : gap_length();
        if (gap != 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_bus.valid     <= 1'b1;
        pix_bus.pixel_rgb <= rgb;
        do
            @(posedge clk);
        while (pix_bus.ready !== 1'b1);
        median_step(rgb, produced);
    endtask

    // stop offering, wait for every predicted beat; always waits for a clock edge
    task automatic drain_results();
        pix_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (filtered_pending.size() != 0);
    endtask

    // register write while idle; border pixels leave work in flight with nothing expected
    task automatic write_register(input logic [rmf_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [rmf_pkg::CFG_DATA_W-1:0] data);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        // bits above the register width are dropped, then the size is saturated
        if (index == rmf_pkg::REG_IMAGE_WIDTH)
            img_width = size_clamp(int'(data[rmf_pkg::WIDTH_REG_W-1:0]), MAX_W);
        else
            img_height = size_clamp(int'(data[rmf_pkg::HEIGHT_REG_W-1:0]), MAX_H);
        // any write restarts the frame, line memories and window are kept
        col_pos = 0;
        row_pos = 0;
    endtask

    // one phase: optional register writes, then a run of pixels sized from the frame
    task automatic run_phase(input bit write_w, input logic [rmf_pkg::CFG_DATA_W-1:0] w_data,
                             input bit write_h, input logic [rmf_pkg::CFG_DATA_W-1:0] h_data,
                             input int unsigned frames, input int unsigned line_cap,
                             input int unsigned extra, input content_kind_t kind,
                             input bit hold_off, input bit mid_pause,
                             output int unsigned sent);
        int unsigned lines;
        int unsigned pause_at;
        bit          produced;
        if (write_w)
            write_register(rmf_pkg::REG_IMAGE_WIDTH, w_data);
        if (write_h)
            write_register(rmf_pkg::REG_IMAGE_HEIGHT, h_data);
        lines = frames * img_height;
        if (lines > line_cap)
            lines = line_cap;
        sent     = lines * img_width + extra;
        pause_at = mid_pause ? $urandom_range(1, sent - 1) : sent;
        if (hold_off)
            hold_requests++;
        for (int unsigned i = 0; i < sent; i++)
        begin
            if (i == pause_at)
                drain_results();
            push_pixel(random_rgb(kind), produced);
        end
    endtask

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // result side: every accepted beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        begin
            if (filtered_pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: beat with nothing expected, expected none, %s %h %0d %0d %0d",
                             $time, "actual", res_bus.out_pixel, res_bus.out_column,
                             res_bus.out_row, res_bus.frame_end);
            end
            else
            begin
                oldest_expected = filtered_pending.pop_front();
                check_field("out_pixel", oldest_expected.pixel, res_bus.out_pixel);
                check_field("out_column", 32'(oldest_expected.column),
                            32'(res_bus.out_column));
                check_field("out_row", 32'(oldest_expected.row), 32'(res_bus.out_row));
                check_field("frame_end", 32'(oldest_expected.frame_end),
                            32'(res_bus.frame_end));
            end
        end
    end

    // receiver: random hold-offs unless steady_sink, or a long one when asked, counted here
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (holds_taken != hold_requests)
            begin
                holds_taken = hold_requests;
                hold_cycles = LONG_HOLD;
            end
            if (hold_cycles != 0)
            begin
                res_bus.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                res_bus.ready <= 1'b1;
                if (!steady_sink && $urandom_range(0, 2) == 0)
                    hold_cycles = gap_length();
            end
        end
        else
        begin
            res_bus.ready <= 1'b0;
        end
    end

    // watchdog on cycles without any beat or register write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1) ||
                (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        int unsigned                    random_items;
        int unsigned                    sent;
        bit                             produced;
        int unsigned                    pick;
        logic [rmf_pkg::CFG_DATA_W-1:0] w_data;
        logic [rmf_pkg::CFG_DATA_W-1:0] h_data;

        // every input known from the start
        pix_bus.valid     <= 1'b0;
        pix_bus.pixel_rgb <= '0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;

        // predictor after reset
        for (int i = 0; i < MAX_W; i++)
        begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        win_cols   = '{'{'0, '0, '0}, '{'0, '0, '0}};
        col_pos    = 0;
        row_pos    = 0;
        img_width  = 32'(rmf_pkg::WIDTH_RESET);
        img_height = 32'(rmf_pkg::HEIGHT_RESET);

        directed_rows = '{
            // below range: width and height saturate to the minimum frame
            write_row(rmf_pkg::REG_IMAGE_WIDTH, rmf_pkg::CFG_DATA_W'(0)),
            write_row(rmf_pkg::REG_IMAGE_HEIGHT, rmf_pkg::CFG_DATA_W'(2)),
            // black frame, single interior pixel, frame end
            pix_row(24'h000000), pix_row(24'h000000), pix_row(24'h000000),
            pix_row(24'h000000), pix_row(24'h000000), pix_row(24'h000000),
            pix_row(24'h000000), pix_row(24'h000000),
            typed_row(24'h000000, '{32'hFF000000, 11'd1, 12'd1, 1'b1}),
            // white frame straight after the wrap
            pix_row(24'hFFFFFF), pix_row(24'hFFFFFF), pix_row(24'hFFFFFF),
            pix_row(24'hFFFFFF), pix_row(24'hFFFFFF), pix_row(24'hFFFFFF),
            pix_row(24'hFFFFFF), pix_row(24'hFFFFFF),
            typed_row(24'hFFFFFF, '{32'hFFFFFFFF, 11'd1, 12'd1, 1'b1}),
            // partial frame, then a write mid-frame restarts at column 0, row 0
            pix_row(24'h123456), pix_row(24'hA5C30F),
            // bit above the width register is dropped
            write_row(rmf_pkg::REG_IMAGE_WIDTH, rmf_pkg::CFG_DATA_W'(13'h1003)),
            write_row(rmf_pkg::REG_IMAGE_HEIGHT, rmf_pkg::CFG_DATA_W'(3)),
            // channels ordered differently, blue with ties
            pix_row(24'h10F000), pix_row(24'h20E0FF), pix_row(24'h30D000),
            pix_row(24'h40C0FF), pix_row(24'h50B080), pix_row(24'h60A0FF),
            pix_row(24'h709000), pix_row(24'h8080FF), pix_row(24'h907000)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power-on sizes: first results of row two check the reset width
        for (int unsigned i = 0; i < RESET_PIXELS; i++)
            push_pixel(random_rgb(CONTENT_UNIFORM), produced);

        // directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
                write_register(directed_rows[i].index, directed_rows[i].data);
            else
            begin
                push_pixel(directed_rows[i].rgb, produced);
                if (directed_rows[i].typed)
                begin
                    if (produced)
                        filtered_pending[filtered_pending.size() - 1] = directed_rows[i].result;
                    else
                        filtered_pending.push_back(directed_rows[i].result);
                end
            end
        end

        // back-pressure: sender keeps offering through a long receiver hold-off,
        // then pauses mid-run until every beat has drained
        steady_src  = 1'b1;
        steady_sink = 1'b0;
        run_phase(1'b1, rmf_pkg::CFG_DATA_W'(5), 1'b1, rmf_pkg::CFG_DATA_W'(40), 1, 12, 3,
                  CONTENT_UNIFORM, 1'b1, 1'b1, sent);

        // tallest frame: saturated height, narrow lines, part of the frame only
        steady_src = 1'b0;
        run_phase(1'b1, rmf_pkg::CFG_DATA_W'(3), 1'b1, rmf_pkg::CFG_DATA_W'(13'h1FFF), 1, 20, 2,
                  CONTENT_EXTREMES, 1'b0, 1'b0, sent);

        // random small frames, whole and broken off, with random idling
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       w_data = rmf_pkg::CFG_DATA_W'($urandom_range(0, 2));
                1:       w_data = rmf_pkg::CFG_DATA_W'(13'h1000 | $urandom_range(3, 10));
                2:       w_data = rmf_pkg::CFG_DATA_W'($urandom_range(13, 40));
                default: w_data = rmf_pkg::CFG_DATA_W'($urandom_range(3, 12));
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:       h_data = rmf_pkg::CFG_DATA_W'($urandom_range(0, 2));
                1:       h_data = rmf_pkg::CFG_DATA_W'($urandom_range(4097, 8191));
                2:       h_data = rmf_pkg::CFG_DATA_W'(MAX_H);
                3:       h_data = rmf_pkg::CFG_DATA_W'($urandom_range(9, 16));
                default: h_data = rmf_pkg::CFG_DATA_W'($urandom_range(3, 8));
            endcase
            steady_src  = ($urandom_range(0, 4) == 0);
            steady_sink = ($urandom_range(0, 4) == 0);
            run_phase($urandom_range(0, 4) != 0, w_data, $urandom_range(0, 4) != 0, h_data,
                      $urandom_range(1, 3), 24,
                      ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 30),
                      content_kind_t'($urandom_range(0, 2)), 1'b0,
                      $urandom_range(0, 3) == 0, sent);
            random_items += sent;
        end

        // all stimulus taken: wait for the last beats, then a quiet tail
        drain_results();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && filtered_pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/rmf_pkg.sv
rtl/rmf_stream_if.sv
rtl/rgb_median_filter_3x3_unit.sv
sim/rgb_median_filter_3x3_unit_test.sv
